[hw/rtl/lud_pkg.sv]
// ----------------------------------------------------------------------------
// lud_pkg
// Shared types, constants and helpers of the uniform integer draw pipeline.
// ----------------------------------------------------------------------------
package lud_pkg;

    localparam int W    = 84;            // magnitude width
    localparam int F    = 48;            // fraction bits
    localparam int IW   = W - F;         // integer bits
    localparam int IDXW = $clog2(W);
    localparam int MANT = 53;

    localparam logic [31:0] SEED_ZERO_SUB = 32'd259341593;
    localparam logic [31:0] LCG_MUL       = 32'd69069;

    localparam logic [1:0] BR_LOW  = 2'd0; // end below maximum
    localparam logic [1:0] BR_TOP  = 2'd1; // end at maximum, start above minimum
    localparam logic [1:0] BR_FULL = 2'd2; // full range

    typedef logic [W-1:0] t_mag;

    typedef struct packed {
        logic neg;
        t_mag mag;
    } t_fx;

    typedef struct packed {
        logic               empty;
        logic [1:0]         br;
        logic signed [31:0] rstart;
        logic signed [31:0] rend;
        logic signed [33:0] lo;
        logic [31:0]        seed;
        logic               sat_hi;
        logic               sat_lo;
    } t_side;

    function automatic t_fx int_to_fx(input logic signed [35:0] v);
        t_fx         r;
        logic [35:0] a;
        r.neg = v[35];
        a     = v[35] ? 36'(-v) : 36'(v);
        r.mag = t_mag'(a) << F;
        return r;
    endfunction

    function automatic logic [IDXW-1:0] msb_idx(input t_mag m);
        logic [IDXW-1:0] idx;
        idx = '0;
        for (int i = 0; i < W; i++) begin
            if (m[i]) idx = IDXW'(i);
        end
        return idx;
    endfunction

endpackage

[hw/rtl/lud_front.sv]
// ----------------------------------------------------------------------------
// lud_front
// Seed update, range widening and exact product of range and fraction.
// ----------------------------------------------------------------------------
module lud_front
    import lud_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [31:0] i_seed,
    input  logic signed [31:0] i_start,
    input  logic signed [31:0] i_end,
    output logic               o_valid,
    output t_mag               o_mag,
    output t_side              o_side
);

    logic [31:0]        st0, st;
    logic [22:0]        m;
    logic [46:0]        u;
    logic signed [33:0] hi, lo;
    t_side              side;

    always_comb begin
        st0 = (i_seed == 32'sd0) ? SEED_ZERO_SUB : i_seed;
        st  = st0 * LCG_MUL + 32'd1;
        m   = st[22:0];
        u   = {1'b0, m, 23'b0} + 47'(m) + 47'h800000;
        side.empty  = (i_start >= i_end);
        side.rstart = i_start;
        side.rend   = i_end;
        side.sat_hi = 1'b0;
        side.sat_lo = 1'b0;
        if (i_end != 32'sh7fffffff) begin
            side.br = BR_LOW;
            lo      = 34'(i_start);
            hi      = 34'(i_end) + 34'sd1;
        end else if (i_start != 32'sh80000000) begin
            side.br = BR_TOP;
            lo      = 34'(i_start) - 34'sd1;
            hi      = 34'(i_end);
        end else begin
            side.br = BR_FULL;
            lo      = 34'(i_start);
            hi      = 34'(i_end);
        end
        side.lo   = lo;
        side.seed = side.empty ? i_seed : st;
    end

    logic        r1_valid, r2_valid;
    logic [46:0] r1_u;
    logic [31:0] r1_d;
    t_side       r1_side, r2_side;
    logic [63:0] r2_pl;
    logic [46:0] r2_ph;
    logic [78:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            o_valid  <= r2_valid;
        end
        r1_u    <= u;
        r1_d    <= 32'(hi - lo);
        r1_side <= side;
        r2_pl   <= {32'b0, r1_d} * {32'b0, r1_u[31:0]};
        r2_ph   <= 47'(r1_d) * 47'(r1_u[46:32]);
        r2_side <= r1_side;
        o_mag   <= t_mag'(prod) << 2;
        o_side  <= r2_side;
    end

    assign prod = 79'(r2_pl) + {r2_ph, 32'b0};

endmodule

[hw/rtl/lud_rnd_add.sv]
// ----------------------------------------------------------------------------
// lud_rnd_add
// Sign-magnitude add, leading-one search and round to 53 bits, nearest-even.
// ----------------------------------------------------------------------------
module lud_rnd_add
    import lud_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_fx   i_a,
    input  t_fx   i_b,
    input  logic  i_sticky,
    input  t_side i_side,
    output logic  o_valid,
    output t_fx   o_res,
    output t_side o_side
);

    t_fx n_sum;

    always_comb begin
        if (i_a.neg == i_b.neg) begin
            n_sum.neg = i_a.neg;
            n_sum.mag = i_a.mag + i_b.mag;
        end else if (i_a.mag >= i_b.mag) begin
            n_sum.neg = i_a.neg;
            n_sum.mag = i_a.mag - i_b.mag;
        end else begin
            n_sum.neg = i_b.neg;
            n_sum.mag = i_b.mag - i_a.mag;
        end
    end

    logic            r1_valid, r2_valid, r1_sticky, r2_sticky;
    t_fx             r1_sum, r2_sum;
    t_side           r1_side, r2_side;
    logic [IDXW-1:0] r2_idx, k;
    t_mag            lowm, half, rem;
    logic            up;
    t_fx             n_res;

    always_comb begin
        k     = '0;
        lowm  = '0;
        half  = '0;
        rem   = '0;
        up    = 1'b0;
        n_res = r2_sum;
        if (r2_idx > IDXW'(MANT - 1)) begin
            k     = r2_idx - IDXW'(MANT - 1);
            lowm  = (t_mag'(1) << k) - t_mag'(1);
            half  = t_mag'(1) << (k - IDXW'(1));
            rem   = r2_sum.mag & lowm;
            up    = (rem > half) || ((rem == half) && (r2_sticky || r2_sum.mag[k]));
            n_res.mag = (r2_sum.mag & ~lowm) + (up ? (t_mag'(1) << k) : '0);
        end
        if (n_res.mag == '0) n_res.neg = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            o_valid  <= r2_valid;
        end
        r1_sum    <= n_sum;
        r1_sticky <= i_sticky;
        r1_side   <= i_side;
        r2_sum    <= r1_sum;
        r2_sticky <= r1_sticky;
        r2_side   <= r1_side;
        r2_idx    <= msb_idx(r1_sum.mag);
        o_res     <= n_res;
        o_side    <= r2_side;
    end

endmodule

[hw/rtl/lud_div.sv]
// ----------------------------------------------------------------------------
// lud_div
// Truncating divide by 2^32-1 with remainder flag; full range only.
// ----------------------------------------------------------------------------
module lud_div
    import lud_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_fx   i_x,
    input  t_side i_side,
    output logic  o_valid,
    output t_fx   o_q,
    output logic  o_sticky,
    output t_side o_side
);

    localparam logic [35:0] DIVISOR = 36'hffffffff;

    t_mag        e, qp;
    logic [35:0] r0;

    // estimate x + x/2^32 + x/2^64, low by at most two
    always_comb begin
        e  = (i_x.mag >> 32) + (i_x.mag >> 64);
        qp = i_x.mag;
        r0 = '0;
        if (i_side.br == BR_FULL && !i_side.empty) begin
            qp = i_x.mag + e;
            r0 = qp[35:0] - {e[3:0], 32'b0};
        end
    end

    logic        r1_valid, r1_neg;
    t_mag        r1_qp;
    logic [35:0] r1_r0, rem;
    t_side       r1_side;
    logic [1:0]  c;

    always_comb begin
        if (r1_r0 >= {DIVISOR[34:0], 1'b0}) begin
            c   = 2'd2;
            rem = r1_r0 - {DIVISOR[34:0], 1'b0};
        end else if (r1_r0 >= DIVISOR) begin
            c   = 2'd1;
            rem = r1_r0 - DIVISOR;
        end else begin
            c   = 2'd0;
            rem = r1_r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            o_valid  <= r1_valid;
        end
        r1_qp     <= qp;
        r1_r0     <= r0;
        r1_neg    <= i_x.neg;
        r1_side   <= i_side;
        o_q.mag   <= r1_qp + t_mag'(c);
        o_q.neg   <= r1_neg;
        o_sticky  <= (rem != '0);
        o_side    <= r1_side;
    end

endmodule

[hw/rtl/lud_back.sv]
// ----------------------------------------------------------------------------
// lud_back
// Integer conversion, per-branch clamp and result register.
// ----------------------------------------------------------------------------
module lud_back
    import lud_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_fx                i_s,
    input  t_side              i_side,
    output logic               o_strobe,
    output logic signed [31:0] o_drawn,
    output logic signed [31:0] o_seed
);

    logic [IW-1:0]      ip;
    logic signed [37:0] v, vs, ve, vl;
    logic signed [31:0] n_drawn;

    always_comb begin
        ip = i_s.mag[W-1:F];
        v  = i_s.neg ? -$signed({2'b0, ip}) : $signed({2'b0, ip});
        vs = 38'(i_side.rstart);
        ve = 38'(i_side.rend);
        vl = 38'(i_side.lo);
        n_drawn = v[31:0];
        if (i_side.empty) begin
            n_drawn = i_side.rstart;
        end else begin
            case (i_side.br)
                BR_LOW: begin
                    if (v < vs) n_drawn = i_side.rstart;
                    else if (v >= ve + 38'sd1) n_drawn = i_side.rend;
                end
                BR_TOP: begin
                    if (v <= vl) n_drawn = i_side.rstart;
                    else if (v > ve) n_drawn = i_side.rend;
                end
                BR_FULL: begin
                    if (i_side.sat_hi) n_drawn = 32'sh7fffffff;
                    else if (i_side.sat_lo) n_drawn = 32'sh80000000;
                end
                default: n_drawn = v[31:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_valid;
        end
        o_drawn <= n_drawn;
        o_seed  <= i_side.seed;
    end

endmodule

[hw/rtl/lcg_uniform_integer_draw.sv]
// Throughput: one draw per cycle; busy is always low, the pipeline never stalls.
// Cost sits in the chain of 53-bit rounding units, three stages each.
// Reset is synchronous, active low, and clears all valid bits at once.
// The result shows for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// lcg_uniform_integer_draw
// Pipelined LCG uniform integer draw with exact double-rounding emulation.
// ----------------------------------------------------------------------------
module lcg_uniform_integer_draw
    import lud_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_seed_in,
    input  logic signed [31:0] i_range_start,
    input  logic signed [31:0] i_range_end,
    output logic               o_strobe,
    output logic signed [31:0] o_drawn_value,
    output logic signed [31:0] o_seed_out
);

    localparam int LAT = 24;

    assign busy = 1'b0;

    logic  v0, v1, v2, v3, v4, v5, v6, v7;
    t_mag  mag0;
    t_side s0, s1, s2, s3, s4, s5, s6, s7, s6m;
    t_fx   x1, x2, x3, x4, x5, x6, x7;
    t_fx   b2, b6, b7;
    logic  st4;

    lud_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start && !busy),
        .i_seed(i_seed_in), .i_start(i_range_start), .i_end(i_range_end),
        .o_valid(v0), .o_mag(mag0), .o_side(s0)
    );

    lud_rnd_add u_rnd_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v0),
        .i_a('{neg: 1'b0, mag: mag0}), .i_b('0), .i_sticky(1'b0), .i_side(s0),
        .o_valid(v1), .o_res(x1), .o_side(s1)
    );

    lud_rnd_add u_add_lo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v1),
        .i_a(x1), .i_b(int_to_fx(36'(s1.lo))), .i_sticky(1'b0), .i_side(s1),
        .o_valid(v2), .o_res(x2), .o_side(s2)
    );

    always_comb begin
        case (s2.br)
            BR_TOP:  b2 = int_to_fx(36'sd1);
            BR_FULL: b2 = int_to_fx(36'sd2147483648);
            default: b2 = '0;
        endcase
    end

    lud_rnd_add u_add_hi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v2),
        .i_a(x2), .i_b(b2), .i_sticky(1'b0), .i_side(s2),
        .o_valid(v3), .o_res(x3), .o_side(s3)
    );

    lud_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v3),
        .i_x(x3), .i_side(s3),
        .o_valid(v4), .o_q(x4), .o_sticky(st4), .o_side(s4)
    );

    lud_rnd_add u_rnd_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v4),
        .i_a(x4), .i_b('0), .i_sticky(st4), .i_side(s4),
        .o_valid(v5), .o_res(x5), .o_side(s5)
    );

    assign b6 = (s5.br == BR_FULL) ? int_to_fx(-36'sd2147483648) : '0;

    lud_rnd_add u_add_off (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v5),
        .i_a(x5), .i_b(b6), .i_sticky(1'b0), .i_side(s5),
        .o_valid(v6), .o_res(x6), .o_side(s6)
    );

    // saturation is judged on the value before the negative-side step
    always_comb begin
        s6m        = s6;
        s6m.sat_hi = (s6.br == BR_FULL) && !x6.neg &&
                     (x6.mag[W-1:F] >= IW'(32'h7fffffff));
        s6m.sat_lo = (s6.br == BR_FULL) && x6.neg &&
                     (x6.mag[W-1:F] >= IW'(33'h080000000));
        b7         = x6.neg ? int_to_fx(-36'sd1) : '0;
    end

    lud_rnd_add u_add_neg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v6),
        .i_a(x6), .i_b(b7), .i_sticky(1'b0), .i_side(s6m),
        .o_valid(v7), .o_res(x7), .o_side(s7)
    );

    lud_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v7),
        .i_s(x7), .i_side(s7),
        .o_strobe(o_strobe), .o_drawn(o_drawn_value), .o_seed(o_seed_out)
    );

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_strobe)
        else $error("transfer lost in pipeline");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("strobe without transfer");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_range_start >= i_range_end, LAT))
        |-> (o_drawn_value == $past(i_range_start, LAT)) &&
            (o_seed_out == $past(i_seed_in, LAT)))
        else $error("empty range not passed through");

    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_range_start < i_range_end, LAT))
        |-> (o_drawn_value >= $past(i_range_start, LAT)) &&
            (o_drawn_value <= $past(i_range_end, LAT)))
        else $error("draw outside range");

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Checks the uniform integer draw pipeline. Each accepted draw request is run
// through a bit-exact model of the double-rounded LCG draw. Each strobed result
// is then compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  MAX32     = 32'h7fffffff;
    localparam int  MIN32     = 32'h80000000;
    localparam int  N_RANDOM  = 780;
    localparam int  DRAIN_CYC = 40;

    typedef logic [127:0] mag_t;
    typedef struct {
        bit   neg;
        mag_t m;
    } fx_t;
    typedef struct {
        int drawn;
        int seed;
    } draw_t;

    class draw_scoreboard;
        draw_t pending[$];
        int    errors;

        function int msb_of(mag_t m);
            int r;
            r = -1;
            for (int i = 0; i < 128; i++) begin
                if (m[i]) r = i;
            end
            return r;
        endfunction

        function mag_t round_53(mag_t m, bit sticky);
            int   b;
            int   k;
            mag_t keep;
            mag_t rem;
            mag_t half;
            b = msb_of(m);
            if (b <= 52) return m;
            k    = b - 52;
            keep = m >> k;
            rem  = m - (keep << k);
            half = mag_t'(1) << (k - 1);
            if (rem > half || (rem == half && (sticky || keep[0]))) keep = keep + 1;
            return keep << k;
        endfunction

        function fx_t fx_from_int(longint v);
            fx_t r;
            r.neg = v < 0;
            r.m   = mag_t'(r.neg ? -v : v) << 80;
            return r;
        endfunction

        function fx_t fx_sum(fx_t a, fx_t b);
            fx_t r;
            if (a.neg == b.neg) begin
                r.neg = a.neg;
                r.m   = a.m + b.m;
            end else if (a.m >= b.m) begin
                r.neg = a.neg;
                r.m   = a.m - b.m;
            end else begin
                r.neg = b.neg;
                r.m   = b.m - a.m;
            end
            r.m = round_53(r.m, 1'b0);
            if (r.m == 0) r.neg = 1'b0;
            return r;
        endfunction

        function longint int_part(fx_t a);
            mag_t t;
            t = a.m >> 80;
            return longint'(t[63:0]);
        endfunction

        function longint fx_trunc(fx_t s);
            fx_t t;
            if (!s.neg) return int_part(s);
            t = fx_sum(s, fx_from_int(-1));
            return t.neg ? -int_part(t) : int_part(t);
        endfunction

        function draw_t draw_uniform(int seed, int rstart, int rend);
            draw_t       r;
            logic [31:0] st;
            logic [63:0] u;
            longint      lo;
            longint      span;
            longint      v;
            fx_t         p;
            fx_t         s;
            fx_t         x;
            fx_t         y;
            fx_t         q;
            mag_t        rem;
            if (rstart >= rend) begin
                r.drawn = rstart;
                r.seed  = seed;
                return r;
            end
            st = seed;
            if (st == 0) st = 32'd259341593;
            st = st * 32'd69069 + 32'd1;
            u  = 64'(st[22:0]) * 64'h800001 + 64'h800000;
            if (rend != MAX32) lo = rstart;
            else if (rstart != MIN32) lo = longint'(rstart) - 1;
            else lo = rstart;
            span  = ((rend != MAX32) ? longint'(rend) + 1 : longint'(rend)) - lo;
            p.neg = 1'b0;
            p.m   = round_53((mag_t'(span) * mag_t'(u)) << 34, 1'b0);
            if (rend != MAX32) begin
                s = fx_sum(p, fx_from_int(lo));
                v = fx_trunc(s);
                if (v < rstart) v = rstart;
                if (v >= longint'(rend) + 1) v = rend;
            end else if (rstart != MIN32) begin
                s = fx_sum(fx_sum(p, fx_from_int(lo)), fx_from_int(1));
                v = fx_trunc(s);
                if (v <= lo) v = rstart;
                if (v > rend) v = rend;
            end else begin
                x     = fx_sum(p, fx_from_int(-64'sd2147483648));
                y     = fx_sum(x, fx_from_int(64'sd2147483648));
                rem   = y.m % mag_t'(32'hffffffff);
                q.neg = y.neg;
                q.m   = round_53(y.m / mag_t'(32'hffffffff), rem != 0) << 32;
                s     = fx_sum(q, fx_from_int(-64'sd2147483648));
                if (!s.neg && int_part(s) >= 64'sd2147483647) v = MAX32;
                else if (s.neg && int_part(s) >= 64'sd2147483648) v = MIN32;
                else v = fx_trunc(s);
            end
            r.drawn = int'(v);
            r.seed  = st;
            return r;
        endfunction

        function void note_request(int seed, int rstart, int rend);
            pending.push_back(draw_uniform(seed, rstart, rend));
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d (0x%08h), expected %0d (0x%08h)",
                     what, got, got, want, want);
            errors++;
        endtask

        task check_result(int drawn, int seed);
            draw_t e;
            if (pending.size() == 0) begin
                $display("MISMATCH unexpected result: drawn %0d seed 0x%08h", drawn, seed);
                errors++;
            end else begin
                e = pending.pop_front();
                if (drawn != e.drawn) report_mismatch("drawn_value", drawn, e.drawn);
                if (seed != e.seed) report_mismatch("seed_out", seed, e.seed);
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] i_seed_in = '0;
    logic signed [31:0] i_range_start = '0;
    logic signed [31:0] i_range_end = '0;
    logic               o_strobe;
    logic signed [31:0] o_drawn_value;
    logic signed [31:0] o_seed_out;

    draw_scoreboard sb = new();
    bit             no_idle = 1'b0;

    lcg_uniform_integer_draw dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_seed_in     (i_seed_in),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_strobe      (o_strobe),
        .o_drawn_value (o_drawn_value),
        .o_seed_out    (o_seed_out)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_request(i_seed_in, i_range_start, i_range_end);
        if (i_rst_n && o_strobe) sb.check_result(o_drawn_value, o_seed_out);
    end

    // called right after a rising edge; returns at the edge that takes the transfer
    task automatic send_draw(int seed, int rstart, int rend);
        bit stalled;
        while (!no_idle && $urandom_range(99) < 28) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_seed_in     <= seed;
        i_range_start <= rstart;
        i_range_end   <= rend;
        do begin
            @(negedge i_clk);
            stalled = busy;
            @(posedge i_clk);
        end while (stalled);
    endtask

    task automatic send_random();
        int seed;
        int a;
        int b;
        int sel;
        seed = ($urandom_range(19) == 0) ? 0 : int'($urandom());
        a    = int'($urandom());
        sel  = $urandom_range(99);
        if (sel < 30) b = int'($urandom());
        else if (sel < 60) b = a + int'($urandom_range(1000));
        else if (sel < 70) begin
            a = a % 1000;
            b = a + int'($urandom_range(3));
        end else if (sel < 82) b = MAX32;
        else if (sel < 90) begin
            a = MIN32;
            b = MAX32;
        end else if (sel < 95) b = a - int'($urandom_range(5));
        else begin
            a = MIN32;
            b = int'($urandom());
        end
        send_draw(seed, a, b);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_draw(32'h12345678, 5, 5);
        send_draw(32'h12345678, 9, -3);
        send_draw(MAX32, MAX32, MIN32);
        send_draw(0, 0, 10);
        send_draw(0, MIN32, MAX32);
        send_draw(1, MIN32, MAX32);
        send_draw(-1, MIN32, MAX32);
        send_draw(MIN32, MIN32, MAX32);
        send_draw(MAX32, MIN32, MAX32);
        send_draw(7, -100, MAX32);
        send_draw(-7, MAX32 - 1, MAX32);
        send_draw(0, 0, MAX32);
        send_draw(123, MIN32, MAX32 - 1);
        send_draw(456, MIN32, MIN32 + 1);
        send_draw(-1, -1, 0);
        send_draw(MIN32, -50, -10);
        send_draw(MAX32, -2000000000, 2000000000);
        send_draw(99, 0, 1);
        send_draw(0, MIN32, 0);
        send_draw(-2, MIN32 + 1, MAX32);
        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle = (n >= 300 && n < 480);
            send_random();
        end
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #500000;
        $display("Verification failed");
        $finish;
    end

endmodule

[lcg_uniform_integer_draw.f]
hw/rtl/lud_pkg.sv
hw/rtl/lud_front.sv
hw/rtl/lud_rnd_add.sv
hw/rtl/lud_div.sv
hw/rtl/lud_back.sv
hw/rtl/lcg_uniform_integer_draw.sv
bench/tb_top.sv
